@@ sv/assert_macros.svh @@
// Assertion helpers, sampled on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define FCS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the next cycle.
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fcs_pkg.sv @@
package fcs_pkg;

	localparam int TEXTURE_BYTES  = 8192;
	localparam int SHADE_ENTRIES  = 256;
	localparam int TEX_AW         = $clog2(TEXTURE_BYTES);
	localparam int TEX_BANK_DEPTH = TEXTURE_BYTES / 2;
	localparam int SHADE_AW       = $clog2(SHADE_ENTRIES);

	localparam int COORD_W = 16;
	localparam int DEST_W  = 16;
	localparam int PIX_W   = 10;
	localparam int DATA_W  = 8;

	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	localparam int CFG_AW    = 3;
	localparam int CFG_IDX_W = CFG_AW - 2;
	localparam int CFG_DW    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_REG_DRAW_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_SHADING   = 1'b1;

	typedef enum logic [1:0] {
		ACT_TEX_LOAD   = 2'd0,
		ACT_SHADE_LOAD = 2'd1,
		ACT_START      = 2'd2,
		ACT_PIXEL      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_CEIL  = 2'd0,
		MODE_FLOOR = 2'd1,
		MODE_BOTH  = 2'd2,
		MODE_NONE  = 2'd3
	} draw_mode_t;

	typedef enum logic [1:0] {
		JOB_TEX_WR   = 2'd0,
		JOB_SHADE_WR = 2'd1,
		JOB_PIXEL    = 2'd2
	} job_kind_t;

	// Work handed from front to back. For pixels, addr is the even texel address.
	typedef struct packed {
		job_kind_t          kind;
		logic [TEX_AW-1:0]  addr;
		logic [DATA_W-1:0]  data;
		logic [DEST_W-1:0]  ceil_addr;
		logic [DEST_W-1:0]  floor_addr;
		logic               ceil_en;
		logic               floor_en;
		logic               row_end;
	} job_t;

	// One pixel's writes waiting for the consumer.
	typedef struct packed {
		logic [DEST_W-1:0]  ceil_addr;
		logic [DATA_W-1:0]  ceil_val;
		logic [DEST_W-1:0]  floor_addr;
		logic [DATA_W-1:0]  floor_val;
		logic               ceil_en;
		logic               floor_en;
		logic               row_end;
	} res_t;

endpackage

@@ sv/floor_ceiling_span_mapper.sv @@
// Textured floor/ceiling span writer.
// Input queue (push/full): load texture byte, load shade entry, start row,
// next pixel. A request is taken when push is high and full is low.
// Result queue (empty/pop): screen writes as pixel_addr/pixel_value pairs,
// oldest first; is_last marks the final write of a pixel, row_end the
// row's last pixel. A pixel gives one write (ceiling or floor only) or two.
// A pixel's first write passes the job queue, texture read, shade read and
// result buffer registers in that order; a full result side can hold it back.
// Requests are taken one per cycle while full is low; results leave one per
// cycle while pop is high; a two-write pixel holds the output for both.
// When pop stays low the 4-entry result buffer and 4-entry job queue fill,
// then full rises; nothing is dropped.
// APB port: register 0 draw_mode at 0x0, register 1 shading_enable at 0x4.
// Reset: draw_mode 2, shading on, no row active, both queues empty.
// Texture and shade memories are not cleared and must be loaded first.
module floor_ceiling_span_mapper (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          action,
	input  logic [fcs_pkg::COORD_W-1:0]         x_frac,
	input  logic [fcs_pkg::COORD_W-1:0]         y_frac,
	input  logic signed [fcs_pkg::COORD_W-1:0]  x_step,
	input  logic signed [fcs_pkg::COORD_W-1:0]  y_step,
	input  logic [fcs_pkg::DEST_W-1:0]          start_dest,
	input  logic signed [fcs_pkg::DEST_W-1:0]   row_offset,
	input  logic [fcs_pkg::PIX_W-1:0]           pixel_count,
	input  logic [fcs_pkg::TEX_AW-1:0]          table_addr,
	input  logic [fcs_pkg::DATA_W-1:0]          table_data,
	output logic                                empty,
	input  logic                                pop,
	output logic [fcs_pkg::DEST_W-1:0]          pixel_addr,
	output logic [fcs_pkg::DATA_W-1:0]          pixel_value,
	output logic                                row_end,
	output logic                                is_last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcs_pkg::CFG_AW-1:0]          paddr,
	input  logic [fcs_pkg::CFG_DW-1:0]          pwdata,
	output logic [fcs_pkg::CFG_DW-1:0]          prdata,
	output logic                                pready
);
	import fcs_pkg::*;

	draw_mode_t           draw_mode_q;
	logic                 shading_q;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic                 cfg_wr;

	logic jq_full;
	logic jq_push;
	job_t jq_in;
	logic jq_empty;
	logic jq_pop;
	job_t jq_head;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q <= MODE_BOTH;
			shading_q   <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_REG_DRAW_MODE: draw_mode_q <= draw_mode_t'(pwdata[1:0]);
				CFG_REG_SHADING:   shading_q   <= pwdata[0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_REG_DRAW_MODE: prdata = CFG_DW'(draw_mode_q);
			CFG_REG_SHADING:   prdata = CFG_DW'(shading_q);
			default:           prdata = '0;
		endcase
	end

	fcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.x_frac      (x_frac),
		.y_frac      (y_frac),
		.x_step      (x_step),
		.y_step      (y_step),
		.start_dest  (start_dest),
		.row_offset  (row_offset),
		.pixel_count (pixel_count),
		.table_addr  (table_addr),
		.table_data  (table_data),
		.draw_mode   (draw_mode_q),
		.q_full      (jq_full),
		.q_push      (jq_push),
		.q_job       (jq_in)
	);

	fcs_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (jq_push),
		.push_job (jq_in),
		.full     (jq_full),
		.pop      (jq_pop),
		.empty    (jq_empty),
		.head     (jq_head)
	);

	fcs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (jq_empty),
		.q_head         (jq_head),
		.q_pop          (jq_pop),
		.shading_enable (shading_q),
		.empty          (empty),
		.pop            (pop),
		.pixel_addr     (pixel_addr),
		.pixel_value    (pixel_value),
		.row_end        (row_end),
		.is_last        (is_last)
	);

endmodule

@@ sv/fcs_front.sv @@
module fcs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    action,
	input  logic [fcs_pkg::COORD_W-1:0]   x_frac,
	input  logic [fcs_pkg::COORD_W-1:0]   y_frac,
	input  logic signed [fcs_pkg::COORD_W-1:0] x_step,
	input  logic signed [fcs_pkg::COORD_W-1:0] y_step,
	input  logic [fcs_pkg::DEST_W-1:0]    start_dest,
	input  logic signed [fcs_pkg::DEST_W-1:0]  row_offset,
	input  logic [fcs_pkg::PIX_W-1:0]     pixel_count,
	input  logic [fcs_pkg::TEX_AW-1:0]    table_addr,
	input  logic [fcs_pkg::DATA_W-1:0]    table_data,
	input  fcs_pkg::draw_mode_t           draw_mode,
	input  logic                          q_full,
	output logic                          q_push,
	output fcs_pkg::job_t                 q_job
);
	import fcs_pkg::*;

	logic [2*COORD_W-1:0] coord_q;
	logic [2*COORD_W-1:0] step_q;
	logic [DEST_W-1:0]    dest_q;
	logic [DEST_W-1:0]    floor_q;
	logic [PIX_W-1:0]     left_q;
	logic                 accept;
	logic                 pix_live;
	action_t              act;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign act      = action_t'(action);
	assign pix_live = (left_q != '0);

	always_comb begin
		q_job            = '0;
		q_push           = 1'b0;
		q_job.kind       = JOB_PIXEL;
		q_job.data       = table_data;
		q_job.ceil_addr  = dest_q;
		q_job.floor_addr = dest_q + floor_q;
		q_job.ceil_en    = (draw_mode == MODE_CEIL) || (draw_mode == MODE_BOTH);
		q_job.floor_en   = (draw_mode == MODE_FLOOR) || (draw_mode == MODE_BOTH);
		q_job.row_end    = (left_q == PIX_W'(1));
		// texel index: y bits 10..15 low, x bits 10..15 high, bit 0 = ceiling
		q_job.addr       = {coord_q[15:10], coord_q[31:26], 1'b0};
		case (act)
			ACT_TEX_LOAD: begin
				q_job.kind = JOB_TEX_WR;
				q_job.addr = table_addr;
				q_push     = accept;
			end
			ACT_SHADE_LOAD: begin
				q_job.kind = JOB_SHADE_WR;
				q_job.addr = table_addr;
				q_push     = accept;
			end
			ACT_PIXEL: begin
				q_push = accept && pix_live && (draw_mode != MODE_NONE);
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
			step_q  <= '0;
			dest_q  <= '0;
			floor_q <= '0;
			left_q  <= '0;
		end else if (accept && act == ACT_START) begin
			coord_q <= {y_frac, x_frac};
			step_q  <= {y_step, x_step};
			dest_q  <= start_dest;
			floor_q <= row_offset;
			left_q  <= pixel_count;
		end else if (accept && act == ACT_PIXEL && pix_live) begin
			coord_q <= coord_q + step_q;
			dest_q  <= dest_q + DEST_W'(1);
			left_q  <= left_q - PIX_W'(1);
		end
	end

endmodule

@@ sv/fcs_jobq.sv @@
module fcs_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcs_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output fcs_pkg::job_t head
);
	import fcs_pkg::*;

	job_t               jobs_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_AW:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = jobs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			jobs_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			cnt_q <= cnt_q + (JOBQ_AW+1)'(do_push) - (JOBQ_AW+1)'(do_pop);
		end
	end

endmodule

@@ sv/fcs_back.sv @@
module fcs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  fcs_pkg::job_t               q_head,
	output logic                        q_pop,
	input  logic                        shading_enable,
	output logic                        empty,
	input  logic                        pop,
	output logic [fcs_pkg::DEST_W-1:0]  pixel_addr,
	output logic [fcs_pkg::DATA_W-1:0]  pixel_value,
	output logic                        row_end,
	output logic                        is_last
);
	import fcs_pkg::*;

	logic [DATA_W-1:0] tex_even_mem [TEX_BANK_DEPTH];
	logic [DATA_W-1:0] tex_odd_mem  [TEX_BANK_DEPTH];
	logic [DATA_W-1:0] shade_mem    [SHADE_ENTRIES];

	logic [TEX_AW-2:0] pair;
	logic              bank_odd;
	logic              tex_wr;
	logic              shade_wr;

	logic              pix_v_s1;
	job_t              job_s1;
	logic [DATA_W-1:0] tex_c_s1;
	logic [DATA_W-1:0] tex_f_s1;

	logic              pix_v_s2;
	job_t              job_s2;
	logic [DATA_W-1:0] raw_c_s2;
	logic [DATA_W-1:0] raw_f_s2;
	logic [DATA_W-1:0] shd_c_s2;
	logic [DATA_W-1:0] shd_f_s2;

	res_t               obuf_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] owr_ptr_q;
	logic [OUTQ_AW-1:0] ord_ptr_q;
	logic [OUTQ_AW:0]   ocnt_q;
	logic               half_q;
	logic [OUTQ_AW+1:0] reserved;
	res_t               new_res;
	res_t               head;
	logic               sel_floor;
	logic               pop_acc;

	assign pair     = q_head.addr[TEX_AW-1:1];
	assign bank_odd = q_head.addr[0];
	assign tex_wr   = q_pop && (q_head.kind == JOB_TEX_WR);
	assign shade_wr = q_pop && (q_head.kind == JOB_SHADE_WR);

	// slots already promised: buffered entries plus pixels in flight
	assign reserved = (OUTQ_AW+2)'(ocnt_q) + (OUTQ_AW+2)'(pix_v_s1) + (OUTQ_AW+2)'(pix_v_s2);
	assign q_pop    = !q_empty && (reserved < (OUTQ_AW+2)'(OUTQ_DEPTH));

	always_ff @(posedge clk) begin
		if (tex_wr && !bank_odd) begin
			tex_even_mem[pair] <= q_head.data;
		end
		tex_c_s1 <= tex_even_mem[pair];
	end

	always_ff @(posedge clk) begin
		if (tex_wr && bank_odd) begin
			tex_odd_mem[pair] <= q_head.data;
		end
		tex_f_s1 <= tex_odd_mem[pair];
	end

	always_ff @(posedge clk) begin
		if (shade_wr) begin
			shade_mem[q_head.addr[SHADE_AW-1:0]] <= q_head.data;
		end
		shd_c_s2 <= shade_mem[tex_c_s1];
		shd_f_s2 <= shade_mem[tex_f_s1];
	end

	always_ff @(posedge clk) begin
		job_s1   <= q_head;
		job_s2   <= job_s1;
		raw_c_s2 <= tex_c_s1;
		raw_f_s2 <= tex_f_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_s1 <= 1'b0;
			pix_v_s2 <= 1'b0;
		end else begin
			pix_v_s1 <= q_pop && (q_head.kind == JOB_PIXEL);
			pix_v_s2 <= pix_v_s1;
		end
	end

	always_comb begin
		new_res.ceil_addr  = job_s2.ceil_addr;
		new_res.floor_addr = job_s2.floor_addr;
		new_res.ceil_val   = shading_enable ? shd_c_s2 : raw_c_s2;
		new_res.floor_val  = shading_enable ? shd_f_s2 : raw_f_s2;
		new_res.ceil_en    = job_s2.ceil_en;
		new_res.floor_en   = job_s2.floor_en;
		new_res.row_end    = job_s2.row_end;
	end

	always_ff @(posedge clk) begin
		if (pix_v_s2) begin
			obuf_q[owr_ptr_q] <= new_res;
		end
	end

	assign head        = obuf_q[ord_ptr_q];
	assign empty       = (ocnt_q == '0);
	assign sel_floor   = half_q || !head.ceil_en;
	assign pixel_addr  = sel_floor ? head.floor_addr : head.ceil_addr;
	assign pixel_value = sel_floor ? head.floor_val : head.ceil_val;
	assign row_end     = head.row_end;
	assign is_last     = sel_floor || !head.floor_en;
	assign pop_acc     = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
			half_q    <= 1'b0;
		end else begin
			if (pix_v_s2) begin
				owr_ptr_q <= owr_ptr_q + OUTQ_AW'(1);
			end
			if (pop_acc) begin
				if (is_last) begin
					ord_ptr_q <= ord_ptr_q + OUTQ_AW'(1);
					half_q    <= 1'b0;
				end else begin
					half_q    <= 1'b1;
				end
			end
			ocnt_q <= ocnt_q + (OUTQ_AW+1)'(pix_v_s2) - (OUTQ_AW+1)'(pop_acc && is_last);
		end
	end

endmodule

@@ sv/fcs_checker.sv @@
`include "assert_macros.svh"

module fcs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  logic                                pop,
	input  logic [fcs_pkg::DEST_W-1:0]          pixel_addr,
	input  logic [fcs_pkg::DATA_W-1:0]          pixel_value,
	input  logic                                row_end,
	input  logic                                is_last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcs_pkg::CFG_AW-1:0]          paddr,
	input  logic [fcs_pkg::CFG_DW-1:0]          pwdata,
	input  logic [fcs_pkg::CFG_DW-1:0]          prdata,
	input  logic                                pready
);
	import fcs_pkg::*;

	// a waiting result holds until popped
	`FCS_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(pixel_addr) && $stable(pixel_value) && $stable(row_end) && $stable(is_last), "result changed while waiting")

	// the floor write of a two-write pixel follows the ceiling write from the same buffer entry
	`FCS_ASSERT_NEXT(a_pair_second, !empty && pop && !is_last, !empty && is_last && (row_end == $past(row_end)), "second write of pixel missing or mismatched")

	// draw mode reads back what was last written
	`FCS_ASSERT_SAME(a_mode_readback, $past(arst_n) && $past(psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == CFG_REG_DRAW_MODE)) && (paddr[CFG_AW-1:2] == CFG_REG_DRAW_MODE), prdata[1:0] == $past(pwdata[1:0]), "draw mode readback mismatch")

endmodule

bind floor_ceiling_span_mapper fcs_checker u_fcs_checker (.*);
